>>> src/rft_pkg.sv
// ----------------------------------------------------------------------------
// rft_pkg
// Shared types and constants of the row fill table min engine.
// ----------------------------------------------------------------------------
package rft_pkg;

	localparam int VALUE_BITS = 32;
	localparam logic signed [VALUE_BITS-1:0] VAL_TOP = {1'b0, {(VALUE_BITS-1){1'b1}}};

	localparam logic [1:0] CFG_ROWS = 2'd0;
	localparam logic [1:0] CFG_COLS = 2'd1;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_FILL  = 2'd1,
		OP_READ  = 2'd2,
		OP_MIN   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_EVAL,
		ST_WL,
		ST_WR,
		ST_LRD,
		ST_LEV,
		ST_ARL,
		ST_ARR,
		ST_AWB,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                         pend;
		logic signed [VALUE_BITS-1:0] vmin;
	} node_t;

endpackage

>>> src/rft_ifs.sv
// ----------------------------------------------------------------------------
// rft request and response channels
// Valid/ready channels carrying one transaction each.
// ----------------------------------------------------------------------------
interface rft_req_if;
	import rft_pkg::*;
	logic        valid;
	logic        ready;
	op_t         op;
	logic [5:0]  row;
	logic [9:0]  col;
	logic signed [31:0] value;
	modport src (output valid, op, row, col, value, input ready);
	modport sink (input valid, op, row, col, value, output ready);
endinterface

interface rft_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] read_value;
	logic        status;
	modport src (output valid, read_value, status, input ready);
	modport sink (input valid, read_value, status, output ready);
endinterface

>>> src/rft_mem.sv
// ----------------------------------------------------------------------------
// rft_mem
// Single-port synchronous node memory, registered read data.
// ----------------------------------------------------------------------------
module rft_mem
	import rft_pkg::*;
#(
	parameter int AW = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  node_t         wdata,
	output node_t         rdata
);

	node_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> src/row_fill_table_min_engine_unit.sv
// ----------------------------------------------------------------------------
// row_fill_table_min_engine_unit
// Table of signed cells, one lazy min segment tree per row in a node memory.
// ----------------------------------------------------------------------------
// After reset the node memory is swept clear, one node a cycle, over all 2**AW
// nodes (131072 by default); no request is taken meanwhile. One request is
// worked at a time by walking one row tree through the single memory port,
// L = clog2(MAX_COLS) levels: a read walks down a level at a time, a cell write
// or row fill walks down pushing pending values to children and then back up
// rewriting each parent's minimum, and the global minimum walks each row in
// use, reading only the row's root when all columns are in use.
// ----------------------------------------------------------------------------
module row_fill_table_min_engine_unit
	import rft_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	rft_req_if.sink     req,
	rft_rsp_if.src      rsp
);

	localparam int L  = $clog2(MAX_COLS);
	localparam int NW = L + 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int AW = RW + NW;
	localparam int DW = $clog2(L + 1);
	localparam logic [L-1:0] ONES = {L{1'b1}};

	state_t state_q, state_d;
	logic [6:0]  rows_q;
	logic [10:0] cols_q;
	op_t         op_q;
	logic [RW-1:0] row_q;
	logic [L-1:0]  tgt_q;
	logic [NW-1:0] node_q;
	logic [DW-1:0] dep_q;
	logic signed [31:0] val_q, acc_q, res_q, lmin_q, pm_q;
	logic        sts_q, pf_q, fl_q;
	logic [AW-1:0] clr_q;
	logic        ov_q, ost_q;
	logic signed [31:0] orv_q;

	logic [10:0] nrows;
	logic [13:0] ncols, colx;
	logic        mem_we;
	logic [NW-1:0] mem_node;
	logic [AW-1:0] mem_addr;
	node_t       mem_wdata, rdata;
	logic [L-1:0] sh;
	logic        bsel, covered;
	logic signed [31:0] amin;

	assign nrows = (11'(rows_q) > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : 11'(rows_q);
	assign ncols = (14'(cols_q) > 14'(MAX_COLS)) ? 14'(MAX_COLS) : 14'(cols_q);
	assign colx  = 14'(req.col);
	assign sh    = tgt_q << dep_q;
	assign bsel  = sh[L-1];
	assign covered = (op_q == OP_FILL || op_q == OP_MIN)
		? (&(tgt_q | ~(ONES >> dep_q))) : (dep_q == DW'(L));
	assign amin  = (rdata.vmin < acc_q) ? rdata.vmin : acc_q;
	assign mem_addr = (state_q == ST_CLEAR) ? clr_q : {row_q, mem_node};

	rft_mem #(.AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (rdata)
	);

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = ov_q;
	assign rsp.read_value = orv_q;
	assign rsp.status     = ost_q;

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_node  = node_q;
		mem_wdata = '{pend: 1'b1, vmin: val_q};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = '{pend: 1'b0, vmin: '0};
				if (&clr_q) state_d = ST_IDLE;
			end
			ST_IDLE: begin
			end
			ST_RD: state_d = ST_EVAL;
			ST_EVAL: begin
				if ((op_q == OP_WRITE || op_q == OP_FILL) && covered) begin
					mem_we = 1'b1;
				end
			end
			ST_WL: begin
				mem_we    = 1'b1;
				mem_node  = node_q << 1;
				mem_wdata = '{pend: 1'b1, vmin: fl_q ? val_q : pm_q};
				state_d   = pf_q ? ST_WR : ST_RD;
			end
			ST_WR: begin
				mem_we    = 1'b1;
				mem_node  = (node_q << 1) | NW'(1);
				mem_wdata = '{pend: 1'b1, vmin: pm_q};
				state_d   = ST_RD;
			end
			ST_LRD: begin
				mem_node = node_q << 1;
				state_d  = ST_LEV;
			end
			ST_LEV: state_d = ST_RD;
			ST_ARL: begin
				mem_node = node_q << 1;
				state_d  = ST_ARR;
			end
			ST_ARR: begin
				mem_node = (node_q << 1) | NW'(1);
				state_d  = ST_AWB;
			end
			ST_AWB: begin
				mem_we    = 1'b1;
				mem_wdata = '{pend: 1'b0, vmin: (rdata.vmin < lmin_q) ? rdata.vmin : lmin_q};
				state_d   = (node_q == NW'(1)) ? ST_FINISH : ST_ARL;
			end
			ST_FINISH: begin
				if (!ov_q || rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_IDLE && req.valid) state_d = ST_FINISH;
		if (state_q == ST_IDLE && req.valid && !(
			(req.op == OP_MIN && (ncols == '0 || nrows == '0)) ||
			(req.op != OP_MIN && 11'(req.row) >= nrows) ||
			((req.op == OP_WRITE || req.op == OP_READ) && colx >= ncols) ||
			(req.op == OP_FILL && ncols == '0)))
			state_d = ST_RD;
		if (state_q == ST_EVAL) begin
			unique case (op_q)
				OP_MIN: begin
					if (covered || rdata.pend) begin
						state_d = (11'(row_q) + 11'd1 < nrows) ? ST_RD : ST_FINISH;
					end else begin
						state_d = bsel ? ST_LRD : ST_RD;
					end
				end
				OP_READ: state_d = (covered || rdata.pend) ? ST_FINISH : ST_RD;
				default: begin
					if (covered) begin
						state_d = (dep_q == '0) ? ST_FINISH : ST_ARL;
					end else if (rdata.pend || (op_q == OP_FILL && bsel)) begin
						state_d = ST_WL;
					end else begin
						state_d = ST_RD;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			rows_q  <= 7'd64;
			cols_q  <= 11'd1024;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROWS: rows_q <= cfg_data[6:0];
					CFG_COLS: cols_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ST_FINISH && (!ov_q || rsp.ready)) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && (!ov_q || rsp.ready)) begin
			orv_q <= res_q;
			ost_q <= sts_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				op_q   <= req.op;
				val_q  <= req.value;
				row_q  <= (req.op == OP_MIN) ? '0 : RW'(req.row);
				tgt_q  <= (req.op == OP_WRITE || req.op == OP_READ)
					? L'(colx) : L'(ncols - 14'd1);
				node_q <= NW'(1);
				dep_q  <= '0;
				acc_q  <= VAL_TOP;
				res_q  <= (req.op == OP_MIN) ? VAL_TOP : '0;
				sts_q  <= (req.op != OP_MIN) && ((11'(req.row) >= nrows) ||
					((req.op == OP_WRITE || req.op == OP_READ) && colx >= ncols));
			end
			ST_EVAL: begin
				pf_q <= rdata.pend;
				pm_q <= rdata.vmin;
				fl_q <= (op_q == OP_FILL) && bsel;
				unique case (op_q)
					OP_MIN: begin
						if (covered || rdata.pend) begin
							acc_q  <= amin;
							res_q  <= amin;
							row_q  <= row_q + RW'(1);
							node_q <= NW'(1);
							dep_q  <= '0;
						end else if (!bsel) begin
							node_q <= node_q << 1;
							dep_q  <= dep_q + DW'(1);
						end
					end
					OP_READ: begin
						res_q <= rdata.vmin;
						if (!(covered || rdata.pend)) begin
							node_q <= (node_q << 1) | NW'(bsel);
							dep_q  <= dep_q + DW'(1);
						end
					end
					default: begin
						if (covered) begin
							node_q <= node_q >> 1;
						end else if (!(rdata.pend || (op_q == OP_FILL && bsel))) begin
							node_q <= (node_q << 1) | NW'(bsel);
							dep_q  <= dep_q + DW'(1);
						end
					end
				endcase
			end
			ST_WL: begin
				if (!pf_q) begin
					node_q <= (node_q << 1) | NW'(bsel);
					dep_q  <= dep_q + DW'(1);
				end
			end
			ST_WR: begin
				node_q <= (node_q << 1) | NW'(bsel);
				dep_q  <= dep_q + DW'(1);
			end
			ST_LEV: begin
				acc_q  <= amin;
				node_q <= (node_q << 1) | NW'(1);
				dep_q  <= dep_q + DW'(1);
			end
			ST_ARR: lmin_q <= rdata.vmin;
			ST_AWB: node_q <= node_q >> 1;
			default: begin
			end
		endcase
	end

endmodule

>>> tb/rft_tb_ifs.sv
// ----------------------------------------------------------------------------
// rft testbench channel note
// The request and response channel interfaces come from the RTL file set;
// this file only adds the shared result record used by the testbench.
// ----------------------------------------------------------------------------
package rft_tb_pkg;
	typedef struct packed {
		logic signed [31:0] read_value;
		logic               status;
	} rft_result_t;
endpackage

>>> tb/row_fill_table_min_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// row_fill_table_min_engine_unit_tb
// Drives cell writes, row fills, cell reads and global minimum requests into
// the engine under several row and column settings, predicts each response
// from a flat table of cells and checks every response field in order.
// ----------------------------------------------------------------------------
module row_fill_table_min_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rft_pkg::*;
	import rft_tb_pkg::*;

	localparam int N_ROWS = 64;
	localparam int N_COLS = 1024;
	localparam longint CYCLE_LIMIT = 4000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;

	rft_req_if req ();
	rft_rsp_if rsp ();

	row_fill_table_min_engine_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req), .rsp(rsp)
	);

	logic signed [31:0] cells [N_ROWS][N_COLS];
	logic [6:0]         rows_reg;
	logic [10:0]        cols_reg;
	rft_result_t        pending_results [$];

	int     send_idle_pct;
	int     recv_idle_pct;
	int     recv_hold;
	int     mismatches;
	int     results_seen;
	int     items_sent;
	longint cycles;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int eff_rows();
		return (rows_reg > N_ROWS) ? N_ROWS : int'(rows_reg);
	endfunction

	function automatic int eff_cols();
		return (cols_reg > N_COLS) ? N_COLS : int'(cols_reg);
	endfunction

	function automatic rft_result_t predict_op(op_t op, logic [5:0] row, logic [9:0] col,
			logic signed [31:0] value);
		rft_result_t r;
		int nr;
		int nc;
		nr = eff_rows();
		nc = eff_cols();
		r.read_value = '0;
		r.status = 1'b0;
		if (op == OP_MIN) begin
			r.read_value = VAL_TOP;
			if (nc > 0)
				for (int i = 0; i < nr; i++)
					for (int j = 0; j < nc; j++)
						if (cells[i][j] < r.read_value) r.read_value = cells[i][j];
		end else if (row >= nr || (op != OP_FILL && col >= nc)) begin
			r.status = 1'b1;
		end else if (op == OP_WRITE) begin
			cells[row][col] = value;
		end else if (op == OP_FILL) begin
			for (int j = 0; j < nc; j++) cells[row][j] = value;
		end else begin
			r.read_value = cells[row][col];
		end
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("[%0t] error: %s", $realtime, msg);
	endtask

	// response side: random stalls plus long hold-offs
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			recv_hold--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		rft_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("response with nothing outstanding");
			end else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status got %b want %b",
						rsp.status, want.status));
				if (rsp.read_value !== want.read_value)
					report_mismatch($sformatf("read_value got %0d want %0d",
						rsp.read_value, want.read_value));
			end
		end
	end

	task automatic send_item(op_t op, logic [5:0] row, logic [9:0] col,
			logic signed [31:0] value);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.op    <= op;
		req.row   <= row;
		req.col   <= col;
		req.value <= value;
		do @(posedge clk); while (!req.ready);
		pending_results.push_back(predict_op(op, row, col, value));
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic set_regs(logic [10:0] rows_val, logic [10:0] cols_val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ROWS;
		cfg_data  <= rows_val;
		@(negedge clk);
		cfg_index <= CFG_COLS;
		cfg_data  <= cols_val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		rows_reg = rows_val[6:0];
		cols_reg = cols_val;
	endtask

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed(32'($urandom_range(0, 15)) - 32'd8);
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic random_items(int count);
		int nr;
		int nc;
		int pick;
		logic [5:0] row;
		logic [9:0] col;
		op_t op;
		nr = eff_rows();
		nc = eff_cols();
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			op = (pick < 35) ? OP_WRITE : (pick < 50) ? OP_FILL :
				(pick < 85) ? OP_READ : OP_MIN;
			row = 6'($urandom());
			col = 10'($urandom());
			if (nr > 0 && $urandom_range(0, 9) < 8) row = 6'($urandom_range(0, nr - 1));
			if (nc > 0 && $urandom_range(0, 9) < 8)
				col = 10'($urandom_range(0, (nc > N_COLS ? N_COLS : nc) - 1));
			send_item(op, row, col, rand_value());
		end
	endtask

	task automatic test_full_table_extremes();
		send_item(OP_MIN, 6'd0, 10'd0, 32'sd0);
		send_item(OP_WRITE, 6'd63, 10'd1023, 32'sh80000000);
		send_item(OP_READ, 6'd63, 10'd1023, 32'sd0);
		send_item(OP_MIN, 6'd0, 10'd0, 32'sd0);
		send_item(OP_FILL, 6'd63, 10'd0, 32'sh7fffffff);
		send_item(OP_READ, 6'd63, 10'd512, 32'sd0);
		send_item(OP_FILL, 6'd63, 10'd0, 32'sd0);
		send_item(OP_READ, 6'd63, 10'd1023, 32'sd0);
		send_item(OP_WRITE, 6'd0, 10'd0, 32'sh7fffffff);
		send_item(OP_READ, 6'd0, 10'd0, 32'sd0);
		drain();
	endtask

	task automatic test_small_and_empty();
		set_regs(11'd1, 11'd1);
		send_item(OP_WRITE, 6'd0, 10'd0, -32'sd5);
		send_item(OP_WRITE, 6'd1, 10'd0, 32'sd3);
		send_item(OP_READ, 6'd0, 10'd1, 32'sd0);
		send_item(OP_MIN, 6'd0, 10'd0, 32'sd0);
		send_item(OP_FILL, 6'd0, 10'd0, 32'sd9);
		send_item(OP_READ, 6'd0, 10'd0, 32'sd0);
		drain();
		set_regs(11'd0, 11'd0);
		send_item(OP_MIN, 6'd0, 10'd0, 32'sd0);
		send_item(OP_FILL, 6'd0, 10'd0, 32'sd1);
		send_item(OP_WRITE, 6'd0, 10'd0, 32'sd1);
		drain();
		set_regs(11'd2, 11'd0);
		send_item(OP_FILL, 6'd1, 10'd0, -32'sd1);
		send_item(OP_MIN, 6'd0, 10'd0, 32'sd0);
		drain();
		set_regs(11'd127, 11'd2047);
		send_item(OP_READ, 6'd0, 10'd1, 32'sd0);
		send_item(OP_READ, 6'd0, 10'd0, 32'sd0);
		send_item(OP_MIN, 6'd0, 10'd0, 32'sd0);
		drain();
	endtask

	task automatic test_random_phase(int rows_val, int cols_val, int sp, int rp, int count);
		set_regs(11'(rows_val), 11'(cols_val));
		send_idle_pct = sp;
		recv_idle_pct = rp;
		random_items(count);
		drain();
	endtask

	task automatic test_backpressure();
		set_regs(11'd3, 11'd4);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold = 600;
		random_items(60);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ROWS;
		cfg_data = '0;
		req.valid = 1'b0;
		req.op = OP_WRITE;
		req.row = '0;
		req.col = '0;
		req.value = '0;
		rsp.ready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold = 0;
		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		cycles = 0;
		rows_reg = 7'd64;
		cols_reg = 11'd1024;
		foreach (cells[i, j]) cells[i][j] = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_full_table_extremes();
		test_small_and_empty();
		test_random_phase(5, 12, 23, 58, 300);
		test_random_phase(2, 3, 58, 23, 200);
		test_random_phase(64, 1024, 58, 23, 100);
		test_random_phase(17, 40, 0, 0, 260);
		test_backpressure();

		$display("run covered %0d requests and %0d responses over ten row/column settings",
			items_sent, results_seen);
		$display("including empty, oversize and full tables, and a long response stall");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
